// ===== src/adpcm_frame_decoder_top_assert.svh =====
// Assertion macros for the ADPCM frame decoder.
// Used by adpcm_frame_decoder_top.sv; expects clk and rst_n in scope.
`ifndef ADPCM_FRAME_DECODER_TOP_ASSERT_SVH
`define ADPCM_FRAME_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ADPCM_CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adpcm assertion failed");

// Next-cycle implication, checked outside reset
`define ADPCM_CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adpcm assertion failed");

`endif

// ===== src/adpcm_pkg.sv =====
// Shared constants, types and helpers for the ADPCM frame decoder.
// No dependencies; used by all decoder modules.
package adpcm_pkg;

  localparam int NUM_CHANNELS  = 2;
  localparam int CH_IDX_W      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FRAME_SAMPLES = 14;
  localparam int SAMPLE_IDX_W  = 4;
  localparam int COEF_PAIRS    = 8;
  localparam int PAIR_W        = 3;
  localparam int SCALE_W       = 4;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 32;
  localparam int FRAME_W       = 64;
  localparam int DATA_W        = 56;
  localparam int SAMPLE_W      = 16;
  localparam int PRED_SHIFT    = 11;

  localparam logic [SAMPLE_IDX_W-1:0] LAST_IDX = SAMPLE_IDX_W'(FRAME_SAMPLES - 1);

  typedef logic [CFG_DATA_W-1:0] coef_word_t;

  localparam coef_word_t COEF_RESET [COEF_PAIRS] = '{
    32'd44172304, 32'd235862326, 32'd148831673, 32'd260044879,
    32'd99352957, 32'd226359876, 32'd170851735, 32'd248772897
  };

  // One decoded frame command, front to back
  typedef struct packed {
    logic                       chan;
    logic signed [SAMPLE_W-1:0] c1;
    logic signed [SAMPLE_W-1:0] c2;
    logic [SCALE_W-1:0]         scale;
    logic [DATA_W-1:0]          data;
  } cmd_t;

  // Back-end status, for observation at the top
  typedef struct packed {
    logic                    busy;
    logic                    step;
    logic [SAMPLE_IDX_W-1:0] idx;
  } back_stat_t;

  // History slot for a channel number (wraps modulo NUM_CHANNELS)
  function automatic logic [CH_IDX_W-1:0] ch_index(input logic chan);
    logic [CH_IDX_W-1:0] idx;
    if (NUM_CHANNELS > 1) begin
      idx = CH_IDX_W'(chan);
    end else begin
      idx = '0;
    end
    return idx;
  endfunction

endpackage

// ===== src/adpcm_frame_decoder_top.sv =====
// Channel    | Handshake            | Payload
// ---------- | -------------------- | --------------------------------------
// input      | in_push / in_full    | in_chan, in_frame_bits
// result     | out_pop / out_empty  | out_pcm_sample, out_chan, out_frame_last
// config     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each frame yields 14 samples, one per cycle while not stalled, a rate set by the
// history feedback through the two predictor multipliers and the saturating add.
// Frames follow each other without a gap; a two-entry command queue sits in front.
// A full two-entry result queue stalls the sample sequencer; no other stalls.
// Reset (rst_n low, synchronous) clears history and queues and reloads the
// default coefficient pairs.
// Top level of the ADPCM frame decoder; depends on adpcm_pkg, adpcm_front,
// adpcm_back and adpcm_frame_decoder_top_assert.svh.
`include "adpcm_frame_decoder_top_assert.svh"

module adpcm_frame_decoder_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [adpcm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic                                   in_chan,
  input  logic [adpcm_pkg::FRAME_W-1:0]          in_frame_bits,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [adpcm_pkg::SAMPLE_W-1:0]  out_pcm_sample,
  output logic                                   out_chan,
  output logic                                   out_frame_last
);

  logic                  cmd_valid;
  logic                  cmd_ready;
  adpcm_pkg::cmd_t       cmd;
  adpcm_pkg::back_stat_t stat;

  // Accept and decode frames
  adpcm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_chan       (in_chan),
    .in_frame_bits (in_frame_bits),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Produce samples
  adpcm_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .cmd            (cmd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_pcm_sample (out_pcm_sample),
    .out_chan       (out_chan),
    .out_frame_last (out_frame_last),
    .stat           (stat)
  );

  // An accepted frame is visible to the back end on the next cycle
  `ADPCM_CHK_NEXT(a_push_reaches_queue, in_push && !in_full, cmd_valid)
  // Every produced sample lands in the result queue
  `ADPCM_CHK_NEXT(a_step_fills_output, stat.step, !out_empty)
  // A frame in progress stays busy until its last sample
  `ADPCM_CHK_NEXT(a_busy_until_last,
    stat.step && (stat.idx != adpcm_pkg::LAST_IDX), stat.busy)
  // The back end takes a new frame mid-run only on its last sample
  `ADPCM_CHK_NOW(a_load_on_last, cmd_valid && cmd_ready && stat.busy,
    stat.step && (stat.idx == adpcm_pkg::LAST_IDX))

endmodule

// ===== src/adpcm_front.sv =====
// Front end: coefficient registers, header decode and a two-entry command queue.
// Depends on adpcm_pkg.
module adpcm_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adpcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [adpcm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                               in_push,
  output logic                               in_full,
  input  logic                               in_chan,
  input  logic [adpcm_pkg::FRAME_W-1:0]      in_frame_bits,
  output logic                               cmd_valid,
  input  logic                               cmd_ready,
  output adpcm_pkg::cmd_t                    cmd
);

  adpcm_pkg::coef_word_t coef_r [adpcm_pkg::COEF_PAIRS];
  adpcm_pkg::cmd_t       q_r [2];
  logic                  wptr_r, wptr_nxt;
  logic                  rptr_r, rptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  wr_en, rd_en;
  logic [7:0]            header;
  logic [adpcm_pkg::PAIR_W-1:0] pair;
  adpcm_pkg::coef_word_t sel;
  adpcm_pkg::cmd_t       new_cmd;

  // Coefficient register file; out-of-range indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < adpcm_pkg::COEF_PAIRS; k++) begin
        coef_r[k] <= adpcm_pkg::COEF_RESET[k];
      end
    end else if (cfg_valid && (cfg_index < adpcm_pkg::CFG_IDX_W'(adpcm_pkg::COEF_PAIRS))) begin
      coef_r[cfg_index[adpcm_pkg::PAIR_W-1:0]] <= cfg_data;
    end
  end

  // Header decode: pair select in bits 6:4, scale in bits 3:0
  assign header = in_frame_bits[adpcm_pkg::FRAME_W-1 -: 8];
  assign pair   = header[6:4];
  assign sel    = coef_r[pair];

  always_comb begin
    new_cmd       = '0;
    new_cmd.chan  = in_chan;
    new_cmd.c1    = sel[31:16];
    new_cmd.c2    = sel[15:0];
    new_cmd.scale = header[adpcm_pkg::SCALE_W-1:0];
    new_cmd.data  = in_frame_bits[adpcm_pkg::DATA_W-1:0];
  end

  // Command queue
  assign in_full   = (cnt_r == 2'd2);
  assign wr_en     = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign rd_en     = cmd_valid && cmd_ready;
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r ^ wr_en;
    rptr_nxt = rptr_r ^ rd_en;
    cnt_nxt  = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wptr_r] <= new_cmd;
    end
  end

endmodule

// ===== src/adpcm_back.sv =====
// Back end: per-sample sequencer, two-tap predictor, history and result queue.
// Depends on adpcm_pkg.
module adpcm_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_ready,
  input  adpcm_pkg::cmd_t                   cmd,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [adpcm_pkg::SAMPLE_W-1:0] out_pcm_sample,
  output logic                              out_chan,
  output logic                              out_frame_last,
  output adpcm_pkg::back_stat_t             stat
);

  localparam int PROD_W  = 2 * adpcm_pkg::SAMPLE_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int PRED_W  = ACC_W - adpcm_pkg::PRED_SHIFT;
  localparam int RESID_W = 20;
  localparam int SUM_W   = PRED_W + 1;

  // Current frame
  logic                                 busy_r, busy_nxt;
  logic [adpcm_pkg::SAMPLE_IDX_W-1:0]   idx_r, idx_nxt;
  logic                                 chan_r;
  logic signed [adpcm_pkg::SAMPLE_W-1:0] c1_r, c2_r;
  logic [adpcm_pkg::SCALE_W-1:0]        scale_r;
  logic [adpcm_pkg::DATA_W-1:0]         data_r;

  // Channel history
  logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_new_r [adpcm_pkg::NUM_CHANNELS];
  logic signed [adpcm_pkg::SAMPLE_W-1:0] hist_old_r [adpcm_pkg::NUM_CHANNELS];

  // Result queue
  logic signed [adpcm_pkg::SAMPLE_W-1:0] oq_sample_r [2];
  logic                                 oq_chan_r [2];
  logic                                 oq_last_r [2];
  logic                                 oq_wptr_r, oq_wptr_nxt;
  logic                                 oq_rptr_r, oq_rptr_nxt;
  logic [1:0]                           oq_cnt_r, oq_cnt_nxt;
  logic                                 oq_full, oq_rd;

  logic                                 step, last_step, load;
  logic [adpcm_pkg::CH_IDX_W-1:0]       ch;
  logic signed [adpcm_pkg::SAMPLE_W-1:0] h1, h2;
  logic signed [PROD_W-1:0]             p1, p2;
  logic signed [ACC_W-1:0]              acc;
  logic signed [PRED_W-1:0]             pred;
  logic [3:0]                           nib;
  logic signed [RESID_W-1:0]            nib_ext, resid;
  logic signed [SUM_W-1:0]              sum;
  logic signed [adpcm_pkg::SAMPLE_W-1:0] sat;

  // Sequencing: one sample per cycle unless the result queue is full
  assign oq_full   = (oq_cnt_r == 2'd2);
  assign step      = busy_r && !oq_full;
  assign last_step = step && (idx_r == adpcm_pkg::LAST_IDX);
  assign cmd_ready = !busy_r || last_step;
  assign load      = cmd_valid && cmd_ready;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (last_step) begin
      busy_nxt = 1'b0;
    end else if (step) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // Frame payload; data shifts one nibble per sample, high nibble first
  always_ff @(posedge clk) begin
    if (load) begin
      chan_r  <= cmd.chan;
      c1_r    <= cmd.c1;
      c2_r    <= cmd.c2;
      scale_r <= cmd.scale;
      data_r  <= cmd.data;
    end else if (step) begin
      data_r  <= {data_r[adpcm_pkg::DATA_W-5:0], 4'h0};
    end
  end

  // Predictor: floor((h1*c1 + h2*c2) / 2^11)
  assign ch   = adpcm_pkg::ch_index(chan_r);
  assign h1   = hist_new_r[ch];
  assign h2   = hist_old_r[ch];
  assign p1   = PROD_W'(h1) * PROD_W'(c1_r);
  assign p2   = PROD_W'(h2) * PROD_W'(c2_r);
  assign acc  = {p1[PROD_W-1], p1} + {p2[PROD_W-1], p2};
  assign pred = acc[ACC_W-1:adpcm_pkg::PRED_SHIFT];

  // Residual: signed nibble times 2^scale
  assign nib     = data_r[adpcm_pkg::DATA_W-1 -: 4];
  assign nib_ext = {{(RESID_W-4){nib[3]}}, nib};
  assign resid   = nib_ext <<< scale_r;
  assign sum     = {pred[PRED_W-1], pred} + {{(SUM_W-RESID_W){resid[RESID_W-1]}}, resid};

  // Saturate to 16 bits
  always_comb begin
    priority if (sum > SUM_W'(32767)) begin
      sat = 16'sh7FFF;
    end else if (sum < -SUM_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[adpcm_pkg::SAMPLE_W-1:0];
    end
  end

  // History update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < adpcm_pkg::NUM_CHANNELS; k++) begin
        hist_new_r[k] <= '0;
        hist_old_r[k] <= '0;
      end
    end else if (step) begin
      hist_old_r[ch] <= h1;
      hist_new_r[ch] <= sat;
    end
  end

  // Result queue
  assign out_empty      = (oq_cnt_r == 2'd0);
  assign oq_rd          = out_pop && !out_empty;
  assign out_pcm_sample = oq_sample_r[oq_rptr_r];
  assign out_chan       = oq_chan_r[oq_rptr_r];
  assign out_frame_last = oq_last_r[oq_rptr_r];

  always_comb begin
    oq_wptr_nxt = oq_wptr_r ^ step;
    oq_rptr_nxt = oq_rptr_r ^ oq_rd;
    oq_cnt_nxt  = oq_cnt_r + {1'b0, step} - {1'b0, oq_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= 1'b0;
      oq_rptr_r <= 1'b0;
      oq_cnt_r  <= 2'd0;
    end else begin
      oq_wptr_r <= oq_wptr_nxt;
      oq_rptr_r <= oq_rptr_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      oq_sample_r[oq_wptr_r] <= sat;
      oq_chan_r[oq_wptr_r]   <= chan_r;
      oq_last_r[oq_wptr_r]   <= (idx_r == adpcm_pkg::LAST_IDX);
    end
  end

  assign stat.busy = busy_r;
  assign stat.step = step;
  assign stat.idx  = idx_r;

endmodule
